// ----- sv/bfsc_pkg.sv -----
// Shared types and codes for the bitmap find-first-set/clear block.
// Beat payload structs, operation codes and fixed field widths.
// No dependencies.
package bfsc_pkg;

  localparam int OP_W   = 3;
  localparam int IDX_W  = 12;
  localparam int CNT_W  = 13;

  localparam logic [CNT_W-1:0] BITS_IN_USE_RST = 13'd4096;

  localparam logic [OP_W-1:0] OP_SET       = 3'd0;
  localparam logic [OP_W-1:0] OP_CLEAR     = 3'd1;
  localparam logic [OP_W-1:0] OP_TEST      = 3'd2;
  localparam logic [OP_W-1:0] OP_FIND_CLR  = 3'd3;
  localparam logic [OP_W-1:0] OP_FIND_SET  = 3'd4;
  localparam logic [OP_W-1:0] OP_FILL      = 3'd5;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [IDX_W-1:0] bit_index;
    logic             fill_value;
  } in_t;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] found_index;
    logic             test_value;
  } out_t;

endpackage

// ----- sv/bfsc_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module bfsc_ram #(
  parameter int WIDTH  = 64,
  parameter int DEPTH  = 64,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/bitmap_find_first_set_clear.sv -----
// Bitmap allocator top level: set, clear, test, fill and find-first scans.
// Depends on bfsc_pkg (beat types, op codes) and bfsc_ram (bitmap storage).
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-------------------
//  in_     | input     | in_valid / in_ready  | bfsc_pkg::in_t
//  out_    | output    | out_valid / out_ready| bfsc_pkg::out_t
//  cfg_    | input     | cfg_valid / cfg_ready| bits_in_use, 13 bit
//
// One item at a time. Set, clear and test: a reciprocal-multiply step for the
// word, a RAM read, a read-modify-write (test only reads the bit), a result step.
// Out of range index: straight to the result step.
// Find: scan up to NUM_WORDS words, clog2(WORD_BITS) encode steps, check, result.
// Fill: a write to each of the NUM_WORDS words, then the result step.
// After reset a clearing pass writes zeros to every word; in_ready is low.
// A finished result waits in the output register; in_ready returns meanwhile.
module bitmap_find_first_set_clear #(
  parameter int WORD_BITS = 64,
  parameter int NUM_WORDS = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  bfsc_pkg::in_t               in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output bfsc_pkg::out_t              out_data,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [bfsc_pkg::CNT_W-1:0]  cfg_data
);

  import bfsc_pkg::*;

  localparam int AW    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int PW    = $clog2(WORD_BITS);
  localparam int P     = 1 << PW;
  localparam int TOTAL = NUM_WORDS * WORD_BITS;
  localparam int BW    = $clog2(TOTAL + 1);
  localparam int CW    = (BW > CNT_W) ? BW : CNT_W;
  localparam int RS    = IDX_W + PW;
  localparam int RW    = IDX_W + 1;
  localparam int MW    = IDX_W + RW;
  localparam int RECIP = ((1 << RS) + WORD_BITS - 1) / WORD_BITS;

  localparam logic [AW-1:0] LAST = AW'(NUM_WORDS - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_FILL, S_SCAN, S_ENC, S_FIN, S_DIV, S_RD, S_MOD, S_DONE
  } state_t;

  state_t               state_r, state_nxt;
  logic [CNT_W-1:0]     biu_r, biu_nxt;
  logic                 out_valid_r, out_valid_nxt;
  out_t                 out_data_r, out_data_nxt;
  out_t                 res_r, res_nxt;
  logic [OP_W-1:0]      op_r, op_nxt;
  logic [IDX_W-1:0]     idx_r, idx_nxt;
  logic                 fill_r, fill_nxt;
  logic                 rst_pass_r, rst_pass_nxt;
  logic [AW-1:0]        addr_r, addr_nxt;
  logic                 issue_r, issue_nxt;
  logic                 chk_r, chk_nxt;
  logic                 last_r, last_nxt;
  logic                 want_r, want_nxt;
  logic [BW-1:0]        base_r, base_nxt;
  logic [P-1:0]         sh_r, sh_nxt;
  logic [PW-1:0]        half_r, half_nxt;
  logic [PW-1:0]        cnt_r, cnt_nxt;
  logic [PW-1:0]        rem_r, rem_nxt;
  logic [AW-1:0]        q_r, q_nxt;

  logic                 ram_we;
  logic [AW-1:0]        ram_waddr, ram_raddr;
  logic [WORD_BITS-1:0] ram_wdata, ram_rdata;

  logic [WORD_BITS-1:0] scan_v, bit_mask;
  logic [MW-1:0]        prod;
  logic [IDX_W-1:0]     qw;
  logic [PW-1:0]        pos;
  logic [P-1:0]         hi_mask;
  logic [BW-1:0]        where;
  logic                 idx_ok;

  bfsc_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (NUM_WORDS),
    .ADDR_W(AW)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    biu_nxt       = cfg_valid ? cfg_data : biu_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    res_nxt       = res_r;
    op_nxt        = op_r;
    idx_nxt       = idx_r;
    fill_nxt      = fill_r;
    rst_pass_nxt  = rst_pass_r;
    addr_nxt      = addr_r;
    issue_nxt     = issue_r;
    chk_nxt       = 1'b0;
    last_nxt      = 1'b0;
    want_nxt      = want_r;
    base_nxt      = base_r;
    sh_nxt        = sh_r;
    half_nxt      = half_r;
    cnt_nxt       = cnt_r;
    rem_nxt       = rem_r;
    q_nxt         = q_r;

    ram_we    = 1'b0;
    ram_waddr = addr_r;
    ram_wdata = fill_r ? {WORD_BITS{1'b1}} : {WORD_BITS{1'b0}};
    ram_raddr = addr_r;

    scan_v   = want_r ? ram_rdata : ~ram_rdata;
    prod     = MW'(idx_r) * MW'(RECIP);
    qw       = IDX_W'(IDX_W'(q_r) * IDX_W'(WORD_BITS));
    pos      = PW'(WORD_BITS - 1) - rem_r;
    bit_mask = WORD_BITS'(1) << pos;
    hi_mask  = ~({P{1'b1}} >> half_r);
    where    = base_r + BW'(cnt_r);
    idx_ok   = (CW'(in_data.bit_index) < CW'(biu_r)) &&
               (CW'(in_data.bit_index) < CW'(TOTAL));

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt   = in_data.op;
          idx_nxt  = in_data.bit_index;
          fill_nxt = in_data.fill_value;
          res_nxt  = '0;
          unique case (in_data.op) inside
            OP_SET, OP_CLEAR, OP_TEST: begin
              if (idx_ok) begin
                state_nxt = S_DIV;
              end else begin
                state_nxt = S_DONE;
              end
            end
            OP_FIND_CLR, OP_FIND_SET: begin
              want_nxt  = (in_data.op == OP_FIND_SET);
              addr_nxt  = '0;
              issue_nxt = 1'b1;
              base_nxt  = '0;
              state_nxt = S_SCAN;
            end
            OP_FILL: begin
              addr_nxt     = '0;
              rst_pass_nxt = 1'b0;
              state_nxt    = S_FILL;
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      S_FILL: begin
        ram_we   = 1'b1;
        addr_nxt = addr_r + AW'(1);
        if (addr_r == LAST) begin
          rst_pass_nxt = 1'b0;
          state_nxt    = rst_pass_r ? S_IDLE : S_DONE;
        end
      end
      S_SCAN: begin
        if (issue_r) begin
          addr_nxt = addr_r + AW'(1);
          chk_nxt  = 1'b1;
          last_nxt = (addr_r == LAST);
          if (addr_r == LAST) begin
            issue_nxt = 1'b0;
          end
        end
        if (chk_r) begin
          if (scan_v != '0) begin
            sh_nxt    = P'(scan_v) << (P - WORD_BITS);
            half_nxt  = PW'(P / 2);
            cnt_nxt   = '0;
            issue_nxt = 1'b0;
            state_nxt = S_ENC;
          end else begin
            base_nxt = base_r + BW'(WORD_BITS);
            if (last_r) begin
              issue_nxt = 1'b0;
              state_nxt = S_DONE;
            end
          end
        end
      end
      S_ENC: begin
        if ((sh_r & hi_mask) == '0) begin
          sh_nxt  = sh_r << half_r;
          cnt_nxt = cnt_r + half_r;
        end
        half_nxt = half_r >> 1;
        if (half_r == PW'(1)) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (CW'(where) < CW'(biu_r)) begin
          res_nxt.found       = 1'b1;
          res_nxt.found_index = IDX_W'(where);
        end
        state_nxt = S_DONE;
      end
      S_DIV: begin
        q_nxt     = AW'(prod >> RS);
        state_nxt = S_RD;
      end
      S_RD: begin
        ram_raddr = q_r;
        rem_nxt   = PW'(idx_r - qw);
        state_nxt = S_MOD;
      end
      S_MOD: begin
        ram_waddr     = q_r;
        res_nxt.found = 1'b1;
        unique case (op_r)
          OP_SET: begin
            ram_we    = 1'b1;
            ram_wdata = ram_rdata | bit_mask;
          end
          OP_CLEAR: begin
            ram_we    = 1'b1;
            ram_wdata = ram_rdata & ~bit_mask;
          end
          default: begin
            res_nxt.test_value = |(ram_rdata & bit_mask);
          end
        endcase
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_FILL;
      biu_r       <= BITS_IN_USE_RST;
      out_valid_r <= 1'b0;
      rst_pass_r  <= 1'b1;
      fill_r      <= 1'b0;
      addr_r      <= '0;
      issue_r     <= 1'b0;
      chk_r       <= 1'b0;
      last_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      biu_r       <= biu_nxt;
      out_valid_r <= out_valid_nxt;
      rst_pass_r  <= rst_pass_nxt;
      fill_r      <= fill_nxt;
      addr_r      <= addr_nxt;
      issue_r     <= issue_nxt;
      chk_r       <= chk_nxt;
      last_r      <= last_nxt;
    end
    out_data_r <= out_data_nxt;
    res_r      <= res_nxt;
    op_r       <= op_nxt;
    idx_r      <= idx_nxt;
    want_r     <= want_nxt;
    base_r     <= base_nxt;
    sh_r       <= sh_nxt;
    half_r     <= half_nxt;
    cnt_r      <= cnt_nxt;
    rem_r      <= rem_nxt;
    q_r        <= q_nxt;
  end

endmodule

// ----- sv/bfsc_checker.sv -----
// Port-level checker for the bitmap block, bound to the top level.
// Depends on bfsc_pkg (beat types).
module bfsc_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input bfsc_pkg::out_t              out_data
);

  import bfsc_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat dropped or changed while stalled");

  a_clear_pass: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("input taken during clearing pass");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second beat taken while an item is in work");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.found |->
      (out_data.found_index == '0) && !out_data.test_value)
    else $error("miss result carries nonzero index or test value");

endmodule

bind bitmap_find_first_set_clear bfsc_checker u_bfsc_checker (.*);

// ----- test/testbench.sv -----
// Self-checking testbench for bitmap_find_first_set_clear: set, clear, test, fill and
// find-first scans under random idling on the input and result channels.
// Depends on bfsc_pkg and the bitmap_find_first_set_clear RTL; reads no files.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import bfsc_pkg::*;

  localparam int WORD_BITS = 64;
  localparam int NUM_WORDS = 64;
  localparam int CYCLE_LIMIT = 600000;
  localparam int PHASE_BEATS = 110;
  localparam int BURST_BEATS = 100;
  localparam int RANDOM_COUNT = -1;

  localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b1;
  out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CNT_W-1:0] cfg_data = '0;

  logic [WORD_BITS-1:0] bitmap_copy [NUM_WORDS];
  logic [CNT_W-1:0] bit_count = BITS_IN_USE_RST;
  out_t expected_answers [$];

  int errors = 0;
  int cycle_count = 0;
  int op_count [8];
  int find_clr_hits = 0;
  int find_set_hits = 0;
  int count_writes = 0;
  bit quiet = 1'b0;
  bit sender_idles = 1'b1;

  bitmap_find_first_set_clear #(
    .WORD_BITS(WORD_BITS),
    .NUM_WORDS(NUM_WORDS)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d answers outstanding", cycle_count,
               expected_answers.size());
      $display("status: fail");
      $finish;
    end
  end

  function automatic out_t apply_bitmap_op(in_t item);
    out_t res;
    int w;
    int b;
    int hit_at;
    logic want;
    logic [WORD_BITS-1:0] v;
    res = '0;
    case (item.op)
      OP_SET, OP_CLEAR, OP_TEST: begin
        if ({1'b0, item.bit_index} < bit_count) begin
          w = item.bit_index / WORD_BITS;
          b = WORD_BITS - 1 - (item.bit_index % WORD_BITS);
          res.found = 1'b1;
          if (item.op == OP_SET) begin
            bitmap_copy[w][b] = 1'b1;
          end else if (item.op == OP_CLEAR) begin
            bitmap_copy[w][b] = 1'b0;
          end else begin
            res.test_value = bitmap_copy[w][b];
          end
        end
      end
      OP_FIND_CLR, OP_FIND_SET: begin
        want = (item.op == OP_FIND_SET);
        hit_at = -1;
        for (w = 0; w < NUM_WORDS && hit_at < 0; w++) begin
          v = want ? bitmap_copy[w] : ~bitmap_copy[w];
          for (b = 0; b < WORD_BITS && hit_at < 0; b++) begin
            if (v[WORD_BITS-1-b]) hit_at = w * WORD_BITS + b;
          end
        end
        if (hit_at >= 0 && hit_at < int'(bit_count)) begin
          res.found = 1'b1;
          res.found_index = hit_at[IDX_W-1:0];
        end
      end
      OP_FILL: begin
        for (w = 0; w < NUM_WORDS; w++) bitmap_copy[w] = {WORD_BITS{item.fill_value}};
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_answers.size() == 0) begin
        $display("%0t: unexpected beat: expected none, got %p", $time, out_data);
        errors++;
      end else begin
        want = expected_answers.pop_front();
        if (out_data.found !== want.found) begin
          $display("%0t: found mismatch: expected %0d, got %0d", $time, want.found,
                   out_data.found);
          errors++;
        end
        if (out_data.found_index !== want.found_index) begin
          $display("%0t: found_index mismatch: expected %0d, got %0d", $time,
                   want.found_index, out_data.found_index);
          errors++;
        end
        if (out_data.test_value !== want.test_value) begin
          $display("%0t: test_value mismatch: expected %0d, got %0d", $time,
                   want.test_value, out_data.test_value);
          errors++;
        end
      end
    end
  end

  initial begin
    int n;
    forever begin
      if (!quiet && $urandom_range(0, 2) == 0) begin
        n = $urandom_range(1, 7);
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      n = $urandom_range(1, 12);
      out_ready <= 1'b1;
      repeat (n) @(posedge clk);
    end
  end

  task automatic send_op(logic [OP_W-1:0] op, int idx, logic fv);
    in_t item;
    out_t res;
    int gap;
    item.op = op;
    item.bit_index = idx[IDX_W-1:0];
    item.fill_value = fv;
    gap = (sender_idles && $urandom_range(0, 3) == 0) ? $urandom_range(1, 7) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (!in_ready);
    res = apply_bitmap_op(item);
    expected_answers.push_back(res);
    op_count[op]++;
    if (op == OP_FIND_CLR && res.found) find_clr_hits++;
    if (op == OP_FIND_SET && res.found) find_set_hits++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_answers.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_bit_count(int value);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data <= value[CNT_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    bit_count = value[CNT_W-1:0];
    count_writes++;
    cfg_valid <= 1'b0;
  endtask

  task automatic test_empty_map();
    send_op(OP_FIND_CLR, 0, 1'b0);
    send_op(OP_FIND_SET, 0, 1'b1);
    send_op(OP_TEST, 0, 1'b0);
    send_op(OP_TEST, 4095, 1'b1);
    send_op(OP_SET, 0, 1'b0);
    send_op(OP_SET, 4095, 1'b0);
    send_op(OP_TEST, 4095, 1'b0);
    send_op(OP_FIND_SET, 0, 1'b0);
    send_op(OP_CLEAR, 0, 1'b1);
    send_op(OP_FIND_SET, 0, 1'b0);
    send_op(OP_SPARE_LO, 4095, 1'b1);
    send_op(OP_SPARE_HI, 2730, 1'b0);
  endtask

  task automatic test_fill();
    send_op(OP_FILL, 1365, 1'b1);
    send_op(OP_FIND_CLR, 0, 1'b0);
    send_op(OP_CLEAR, 4000, 1'b0);
    send_op(OP_FIND_CLR, 0, 1'b0);
    send_op(OP_FILL, 0, 1'b0);
  endtask

  task automatic test_bit_count_bounds();
    write_bit_count(1);
    send_op(OP_SET, 1, 1'b0);
    send_op(OP_SET, 0, 1'b0);
    send_op(OP_FIND_CLR, 0, 1'b0);
    send_op(OP_FIND_SET, 0, 1'b0);
    write_bit_count(0);
    send_op(OP_TEST, 0, 1'b0);
    send_op(OP_FIND_SET, 0, 1'b0);
    write_bit_count(8191);
    send_op(OP_SET, 4095, 1'b1);
  endtask

  task automatic send_random_beats(int count);
    int i;
    int r;
    int idx;
    int span;
    int win_lo;
    logic [OP_W-1:0] op;
    span = (bit_count > 4096) ? 4096 : int'(bit_count);
    win_lo = (span > 256) ? $urandom_range(0, span - 256) : 0;
    send_op(OP_FILL, $urandom_range(0, 4095), 1'($urandom_range(0, 1)));
    for (i = 1; i < count; i++) begin
      if (i == count / 2) wait_idle();
      r = $urandom_range(0, 99);
      if (r < 28) op = OP_SET;
      else if (r < 50) op = OP_CLEAR;
      else if (r < 64) op = OP_TEST;
      else if (r < 78) op = OP_FIND_CLR;
      else if (r < 92) op = OP_FIND_SET;
      else if (r < 95) op = OP_FILL;
      else op = $urandom_range(0, 1) ? OP_SPARE_HI : OP_SPARE_LO;
      r = $urandom_range(0, 9);
      if (r < 5) begin
        idx = win_lo + $urandom_range(0, 255);
      end else if (r < 7) begin
        idx = int'(bit_count) + $urandom_range(0, 6) - 3;
      end else begin
        idx = $urandom_range(0, 4095);
      end
      if (idx < 0) idx = 0;
      if (idx > 4095) idx = 4095;
      send_op(op, idx, 1'($urandom_range(0, 1)));
    end
  endtask

  task automatic test_random_phases();
    int plan [9] = '{4096, 64, 4095, 1, 0, 8191, RANDOM_COUNT, RANDOM_COUNT, 4096};
    int p;
    for (p = 0; p < 9; p++) begin
      write_bit_count(plan[p] == RANDOM_COUNT ? $urandom_range(1, 4096) : plan[p]);
      send_random_beats(PHASE_BEATS);
    end
  endtask

  task automatic test_back_to_back();
    write_bit_count($urandom_range(1, 4096));
    quiet = 1'b1;
    sender_idles = 1'b0;
    send_random_beats(BURST_BEATS);
  endtask

  initial begin
    foreach (bitmap_copy[w]) bitmap_copy[w] = '0;
    foreach (op_count[k]) op_count[k] = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_map();
    test_fill();
    test_bit_count_bounds();
    test_random_phases();
    test_back_to_back();
    wait_idle();
    repeat (80) @(posedge clk);
    $display("ops: set %0d clear %0d test %0d fill %0d unused %0d", op_count[OP_SET],
             op_count[OP_CLEAR], op_count[OP_TEST], op_count[OP_FILL],
             op_count[OP_SPARE_LO] + op_count[OP_SPARE_HI]);
    $display("scans: clear %0d (%0d hits), set %0d (%0d hits); %0d bit-count writes",
             op_count[OP_FIND_CLR], find_clr_hits, op_count[OP_FIND_SET], find_set_hits,
             count_writes);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- files.f -----
sv/bfsc_pkg.sv
sv/bfsc_ram.sv
sv/bitmap_find_first_set_clear.sv
sv/bfsc_checker.sv
test/testbench.sv
